/* hw/rtl/hse_pkg.sv */
// package for the heap sort engine: item structs, controller states, shared constants
// no dependencies; imported by hse_mem, heap_sort_engine_core and the testbench
`timescale 1ns / 1ps
`default_nettype none

package hse_pkg;

    // value width, fixed by the item format
    localparam int DATA_W    = 32;
    // default store capacity
    localparam int DEPTH_DEF = 64;

    // one input item
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out_item;

    // controller states
    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_BLD_RD,
        S_BLD_HELD,
        S_SWAP_RD,
        S_SWAP_WR,
        S_SD_CMP,
        S_SD_WR,
        S_NEXT,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/hse_mem.sv */
// element store: one write port, two read ports with registered read data
// depends on hse_pkg for the value width
`timescale 1ns / 1ps
`default_nettype none

module hse_mem
    import hse_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr0,
    input  wire logic [AW-1:0]     i_raddr1,
    output logic      [DATA_W-1:0] o_rdata0,
    output logic      [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata0;
    logic [DATA_W-1:0] r_rdata1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two read ports with registered read data
    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

`default_nettype wire

/* hw/rtl/heap_sort_engine_core.sv */
// heap sort engine top level: load, heap build, extraction and result output
// depends on hse_pkg and hse_mem
`timescale 1ns / 1ps
`default_nettype none

// Batch sorter for signed 32-bit values. Items are loaded one per cycle, while
// o_in_stall is low, into a DEPTH-entry store; an item with last set ends the
// batch. Values arriving with the store full are dropped and every result of
// that batch has overflow set. The store then becomes a max-heap (bottom-up
// build); the root is swapped to the end and the old last entry sifted down
// from the root until the heap is empty; results then leave in ascending
// order, the final one with last_out set. The input stalls from the last item
// of a batch until its final result is loaded into the output register. Each
// sift-down fetches the node and its children, moves the hole down one heap
// level per compare, with an extra write of the held value when the hole ends
// on a leaf, then steps to the next node; a batch of n values takes roughly n
// loads, n/2 + n sifts of at most log2(n) levels each, and a store read and an
// output load per result, the last load freeing the input side.
module heap_sort_engine_core
    import hse_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CXW = AW + 2;

    t_state r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_dropped, n_dropped;
    logic                     r_extract, n_extract;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_len, n_len;
    logic [AW-1:0]            r_hole, n_hole;
    logic [CXW-1:0]           r_child, n_child;
    logic signed [DATA_W-1:0] r_held, n_held;
    t_out_item                r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr0;
    logic [AW-1:0]     mem_raddr1;
    logic [DATA_W-1:0] mem_rdata0;
    logic [DATA_W-1:0] mem_rdata1;

    hse_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr0 (mem_raddr0),
        .i_raddr1 (mem_raddr1),
        .o_rdata0 (mem_rdata0),
        .o_rdata1 (mem_rdata1)
    );

    // handshake terms
    logic in_acc;
    logic out_free;
    assign o_in_stall = (r_state != S_LOAD);
    assign in_acc     = i_in_valid && (r_state == S_LOAD);
    assign out_free   = !r_out_valid || !i_out_stall;

    // sift-down compare: pick the larger child, decide whether the hole moves down
    logic [CXW-1:0]           len_x;
    logic [CXW-1:0]           right_idx;
    logic                     use_right;
    logic signed [DATA_W-1:0] big_val;
    logic [CXW-1:0]           big_idx;
    logic                     go_down;
    logic [CXW-1:0]           down_child;
    logic                     down_more;
    assign len_x      = CXW'(r_len);
    assign right_idx  = r_child + CXW'(1);
    assign use_right  = (right_idx < len_x) && ($signed(mem_rdata0) < $signed(mem_rdata1));
    assign big_val    = use_right ? $signed(mem_rdata1) : $signed(mem_rdata0);
    assign big_idx    = use_right ? right_idx : r_child;
    assign go_down    = (r_held < big_val);
    assign down_child = {big_idx[CXW-2:0], 1'b1};
    assign down_more  = (down_child < len_x);

    // swap step: heap shrinks to idx-1 entries
    logic [CW-1:0] idx_m1;
    logic          swap_more;
    assign idx_m1    = r_idx - CW'(1);
    assign swap_more = (CW'(1) < idx_m1);

    // build step: first child of the node being sifted
    logic [CXW-1:0] node_child;
    assign node_child = CXW'({r_idx, 1'b1});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && i_in_item.last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (r_count >= CW'(2)) ? S_BLD_RD : S_SWAP_RD;
            end
            S_BLD_RD:   n_state = S_BLD_HELD;
            S_BLD_HELD: n_state = S_SD_CMP;
            S_SWAP_RD:  n_state = S_SWAP_WR;
            S_SWAP_WR:  n_state = swap_more ? S_SD_CMP : S_SD_WR;
            S_SD_CMP: begin
                if (go_down) begin
                    n_state = down_more ? S_SD_CMP : S_SD_WR;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_SD_WR: n_state = S_NEXT;
            S_NEXT: begin
                if (!r_extract) begin
                    n_state = (r_idx == '0) ? S_SWAP_RD : S_BLD_RD;
                end else begin
                    n_state = (r_idx == CW'(1)) ? S_EMIT_RD : S_SWAP_RD;
                end
            end
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: begin
                if (out_free) begin
                    n_state = (r_idx == r_count - CW'(1)) ? S_LOAD : S_EMIT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // datapath and store access
    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_extract   = r_extract;
        n_idx       = r_idx;
        n_len       = r_len;
        n_hole      = r_hole;
        n_child     = r_child;
        n_held      = r_held;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_hole;
        mem_wdata   = r_held;
        mem_raddr0  = r_idx[AW-1:0];
        mem_raddr1  = r_idx[AW-1:0];

        // result register drains independently
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < CW'(DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = i_in_item.value;
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
            end
            S_START: begin
                n_len = r_count;
                if (r_count >= CW'(2)) begin
                    n_extract = 1'b0;
                    n_idx     = (r_count >> 1) - CW'(1);
                end else begin
                    n_extract = 1'b1;
                    n_idx     = r_count;
                end
            end
            S_BLD_RD: begin
                mem_raddr0 = r_idx[AW-1:0];
            end
            S_BLD_HELD: begin
                n_held     = $signed(mem_rdata0);
                n_hole     = r_idx[AW-1:0];
                n_child    = node_child;
                mem_raddr0 = node_child[AW-1:0];
                mem_raddr1 = AW'(node_child + CXW'(1));
            end
            S_SWAP_RD: begin
                mem_raddr0 = '0;
                mem_raddr1 = idx_m1[AW-1:0];
            end
            S_SWAP_WR: begin
                // root goes to the end, old last entry sifts down from the root
                mem_we     = 1'b1;
                mem_waddr  = idx_m1[AW-1:0];
                mem_wdata  = mem_rdata0;
                n_held     = $signed(mem_rdata1);
                n_hole     = '0;
                n_len      = idx_m1;
                n_child    = CXW'(1);
                mem_raddr0 = AW'(1);
                mem_raddr1 = AW'(CXW'(2));
            end
            S_SD_CMP: begin
                mem_we     = 1'b1;
                mem_waddr  = r_hole;
                mem_raddr0 = down_child[AW-1:0];
                mem_raddr1 = AW'(down_child + CXW'(1));
                if (go_down) begin
                    mem_wdata = big_val;
                    n_hole    = big_idx[AW-1:0];
                    n_child   = down_child;
                end else begin
                    mem_wdata = r_held;
                end
            end
            S_SD_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_hole;
                mem_wdata = r_held;
            end
            S_NEXT: begin
                if (!r_extract) begin
                    if (r_idx == '0) begin
                        n_extract = 1'b1;
                        n_idx     = r_count;
                    end else begin
                        n_idx = idx_m1;
                    end
                end else if (r_idx == CW'(1)) begin
                    n_idx = '0;
                end else begin
                    n_idx = idx_m1;
                end
            end
            S_EMIT_RD: begin
                mem_raddr0 = r_idx[AW-1:0];
            end
            S_EMIT_LD: begin
                mem_raddr0 = r_idx[AW-1:0];
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.sorted_value = $signed(mem_rdata0);
                    n_out.last_out     = (r_idx == r_count - CW'(1));
                    n_out.overflow     = r_dropped;
                    if (r_idx == r_count - CW'(1)) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_idx     = '0;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_extract   <= 1'b0;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_extract   <= n_extract;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hole  <= n_hole;
        r_child <= n_child;
        r_held  <= n_held;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // fill count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above capacity");

    // a dropped value means the store was full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> (r_count == CW'(DEPTH)))
        else $error("drop flagged with free store entries");

    // heap never reaches past the loaded entries
    a_heap_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SD_CMP || r_state == S_SD_WR) |-> (r_len <= r_count))
        else $error("heap length beyond loaded entries");

    // moving the hole down never writes an entry being read for the next level
    a_sift_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SD_CMP && go_down && down_more)
        |-> (mem_waddr != mem_raddr0 && mem_waddr != mem_raddr1))
        else $error("sift write collides with child read");

    // the input side reopens only after the final result of a batch
    a_batch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD && n_state == S_LOAD) |=> (r_out_valid && r_out.last_out))
        else $error("batch ended without a final result");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for heap_sort_engine_core: batches of signed values in, sorted items out
// depends on hse_pkg and the heap_sort_engine_core rtl; predicts each batch and checks every field
`timescale 1ns / 1ps

module tb
    import hse_pkg::*;
();

    localparam int STORE_DEPTH = DEPTH_DEF;
    localparam int CLK_HALF    = 6;
    localparam int RAND_ITEMS  = 330;
    localparam int HOLD_CYCLES = 400;

    // tracks the batch being loaded and the sorted items still owed by the block
    class sort_scoreboard;
        int        capacity;
        int        batch_vals[$];
        bit        batch_dropped;
        t_out_item sorted_q[$];
        int        errors;
        int        results_seen;

        function new(int depth);
            capacity      = depth;
            batch_dropped = 1'b0;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // load one accepted item; a last item sorts the batch into expected results
        function void note_input(t_in_item it);
            int        key;
            int        j;
            t_out_item exp_item;
            if (batch_vals.size() < capacity) begin
                batch_vals.push_back(int'(it.value));
            end else begin
                batch_dropped = 1'b1;
            end
            if (!it.last) begin
                return;
            end
            // ascending insertion sort on signed values
            for (int i = 1; i < batch_vals.size(); i++) begin
                key = batch_vals[i];
                j   = i - 1;
                while (j >= 0 && batch_vals[j] > key) begin
                    batch_vals[j+1] = batch_vals[j];
                    j--;
                end
                batch_vals[j+1] = key;
            end
            foreach (batch_vals[k]) begin
                exp_item.sorted_value = batch_vals[k];
                exp_item.last_out     = (k == batch_vals.size() - 1);
                exp_item.overflow     = batch_dropped;
                sorted_q.push_back(exp_item);
            end
            batch_vals.delete();
            batch_dropped = 1'b0;
        endfunction

        // compare one accepted result against the oldest expectation
        task check_result(t_out_item got);
            t_out_item exp_item;
            results_seen++;
            if (sorted_q.size() == 0) begin
                report($sformatf("unexpected item value %0d", got.sorted_value));
                return;
            end
            exp_item = sorted_q.pop_front();
            if (got.sorted_value !== exp_item.sorted_value) begin
                report($sformatf("item %0d sorted_value got %0d exp %0d", results_seen,
                                 got.sorted_value, exp_item.sorted_value));
            end
            if (got.last_out !== exp_item.last_out) begin
                report($sformatf("item %0d last_out got %b exp %b", results_seen,
                                 got.last_out, exp_item.last_out));
            end
            if (got.overflow !== exp_item.overflow) begin
                report($sformatf("item %0d overflow got %b exp %b", results_seen,
                                 got.overflow, exp_item.overflow));
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    sort_scoreboard sb;
    int             items_sent;
    bit             sender_calm;
    bit             held_off;
    int             pool[$];

    heap_sort_engine_core #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // hard stop
    initial begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // offer one item, with random idle cycles before it, and wait for acceptance
    task send_item(input int val, input bit is_last);
        t_in_item it;
        it.value = val;
        it.last  = is_last;
        if (!sender_calm) begin
            while ($urandom_range(0, 99) < 21) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sb.note_input(it);
        items_sent++;
    endtask

    task send_batch(input int vals[$]);
        foreach (vals[i]) begin
            send_item(vals[i], i == vals.size() - 1);
        end
    endtask

    // hold the input idle until the block has delivered everything owed
    task drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // random value: full range, near zero, extremes, or a repeat of an earlier one
    function int pick_value();
        int v;
        case ($urandom_range(0, 5))
            0:       v = $signed($urandom_range(0, 16)) - 8;
            1: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            2:       v = (pool.size() > 0) ? pool[$urandom_range(0, pool.size() - 1)]
                                           : int'($urandom);
            default: v = $urandom;
        endcase
        if (pool.size() >= 16) begin
            void'(pool.pop_front());
        end
        pool.push_back(v);
        return v;
    endfunction

    // result side: random stalls, one long hold-off, one calm stretch
    initial begin
        out_stall <= 1'b0;
        held_off = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                sb.check_result(out_item);
            end
            if (!held_off && sb.results_seen >= 30) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (sb.results_seen >= 150 && sb.results_seen < 260) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 21);
            end
        end
    end

    // stimulus and end of run
    initial begin
        int vals[$];
        int batch_len;
        int batch_idx;
        sb          = new(STORE_DEPTH);
        items_sent  = 0;
        sender_calm = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single item, extremes, descending, duplicates, alternating bits
        vals = '{5};
        send_batch(vals);
        vals = '{32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 1, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h4000_0000};
        send_batch(vals);
        vals = '{4, 3, 2, 1, 0, -1};
        send_batch(vals);
        vals = '{7, 7, 7};
        send_batch(vals);
        vals = '{32'h8000_0001, 32'h7FFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555};
        send_batch(vals);

        // random batches: mostly short, a full store and an overflowing one forced early
        batch_idx = 0;
        while (items_sent < RAND_ITEMS) begin
            if (batch_idx == 3) begin
                batch_len = STORE_DEPTH;
            end else if (batch_idx == 6) begin
                batch_len = STORE_DEPTH + 3;
            end else if ($urandom_range(0, 11) == 0) begin
                batch_len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
            end else begin
                batch_len = $urandom_range(1, 12);
            end
            sender_calm = (items_sent >= 200 && items_sent < 270);
            vals.delete();
            repeat (batch_len) vals.push_back(pick_value());
            send_batch(vals);
            // one pause until the block has caught up completely
            if (batch_idx == 12) begin
                drain_results();
            end
            batch_idx++;
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
